[rtl/detk_pkg.sv]
// ----------------------------------------------------------------------------
// detk_pkg
// Types and constants shared by the down-counter elapsed time keeper.
// ----------------------------------------------------------------------------
package detk_pkg;

	// Field widths
	localparam int COUNTER_W = 24;
	localparam int TIME_W    = 32;
	localparam int TPU_W     = 24;
	localparam int PERIOD_W  = 25;
	localparam int TICKS_W   = 25;
	localparam int SUM_W     = 26;

	// Register reset values and indexes
	localparam logic [TPU_W-1:0]    TPU_RESET    = TPU_W'(168000);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(8400000);

	typedef enum logic {
		REG_TICKS_PER_UNIT = 1'b0,
		REG_RELOAD_PERIOD  = 1'b1
	} detk_reg_t;

	// Divider: one quotient bit per cycle over the whole sum
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic [COUNTER_W-1:0] counter_value;
		logic [TIME_W-1:0]    start_time;
		logic [TIME_W-1:0]    delay_time;
	} detk_in_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_count;
		logic              interval_passed;
	} detk_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ELAP,
		ST_SUM,
		ST_DIV,
		ST_ADD,
		ST_DIFF,
		ST_FIN
	} detk_state_t;

endpackage

[rtl/detk_if.sv]
// ----------------------------------------------------------------------------
// detk_in_if / detk_out_if
// Valid/ready channels carrying counter samples and time results.
// ----------------------------------------------------------------------------
interface detk_in_if;
	import detk_pkg::*;

	logic     valid;
	logic     ready;
	detk_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface detk_out_if;
	import detk_pkg::*;

	logic      valid;
	logic      ready;
	detk_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/detk_div.sv]
// ----------------------------------------------------------------------------
// detk_div
// Restoring divider, one quotient bit per cycle, remainder kept narrow.
// ----------------------------------------------------------------------------
module detk_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [detk_pkg::SUM_W-1:0]    dividend,
	input  logic [detk_pkg::TPU_W-1:0]    divisor,
	output logic                          done,
	output logic [detk_pkg::SUM_W-1:0]    quotient,
	output logic [detk_pkg::TPU_W-1:0]    remainder
);
	import detk_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [TPU_W-1:0]     part_q;
	logic [SUM_W-1:0]     dq_q;
	logic [TPU_W:0]       trial;
	logic [TPU_W:0]       diff;
	logic                 ge;

	// Shift next dividend bit into the partial remainder and trial subtract
	assign trial = {part_q, dq_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - DIV_CNT_W'(1);
			done_q <= (cnt_q == DIV_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			part_q <= '0;
			dq_q   <= dividend;
		end else if (cnt_q != '0) begin
			part_q <= ge ? diff[TPU_W-1:0] : trial[TPU_W-1:0];
			dq_q   <= {dq_q[SUM_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = part_q;

	// Remainder stays below a nonzero divisor once done
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && divisor != '0) |-> (part_q < divisor))
		else $error("divider remainder not below divisor");

	// Done follows the last step only
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0) && $past(cnt_q == DIV_CNT_W'(1)))
		else $error("divider done without last step");

	// Counter never exceeds step count
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIV_CNT_W'(DIV_STEPS))
		else $error("divider step count out of range");

endmodule

[rtl/downcounter_elapsed_time_keeper_core.sv]
// ----------------------------------------------------------------------------
// downcounter_elapsed_time_keeper_core
// Turns down-counter samples into a wrapping unit count and an interval test.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  sample   | in  | valid/ready      | counter_value, start_time, delay_time
//  result   | out | valid/ready      | time_count, interval_passed
//  cfg      | in  | cfg_we           | cfg_index, cfg_wdata (no read-back)
//
//  One sample is in work at a time. Acceptance to result includes the
//  bit-serial divide of the 26-bit tick sum by ticks_per_unit; the priming
//  sample and a zero ticks_per_unit skip it.
//  arst_n clears the state; no clearing pass is needed.
//  A held result does not block acceptance; the block stalls only in its finish
//  state while the previous result is still not taken.
// ----------------------------------------------------------------------------
module downcounter_elapsed_time_keeper_core (
	input  logic                           clk,
	input  logic                           arst_n,
	detk_in_if.sink                        sample,
	detk_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [detk_pkg::PERIOD_W-1:0]  cfg_wdata
);
	import detk_pkg::*;

	detk_state_t state_q, state_d;

	logic [TPU_W-1:0]     tpu_q;
	logic [PERIOD_W-1:0]  period_q;
	logic                 first_q;
	logic [COUNTER_W-1:0] prev_q;
	logic [TICKS_W-1:0]   rem_q;
	logic [TIME_W-1:0]    unit_q;
	logic                 res_valid_q;
	detk_out_t            res_data_q;

	logic [COUNTER_W-1:0] cur_q;
	logic [TIME_W-1:0]    start_q;
	logic [TIME_W-1:0]    delay_q;
	logic [TICKS_W-1:0]   elapsed_q;
	logic [TIME_W-1:0]    diff_q;

	logic                 accept;
	logic                 out_free;
	logic                 div_start;
	logic                 div_done;
	logic [SUM_W-1:0]     div_quot;
	logic [TPU_W-1:0]     div_rem;
	logic [TICKS_W-1:0]   elapsed_d;
	logic [SUM_W-1:0]     sum_d;
	logic                 in_ready;

	assign accept   = sample.valid && in_ready;
	assign out_free = !res_valid_q || result.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = first_q ? ST_DIFF : ST_ELAP;
			ST_ELAP: state_d = ST_SUM;
			ST_SUM:  state_d = (tpu_q == '0) ? ST_DIFF : ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_ADD;
			ST_ADD:  state_d = ST_DIFF;
			ST_DIFF: state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_SUM:  div_start = (tpu_q != '0);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q    <= TPU_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (detk_reg_t'(cfg_index))
				REG_TICKS_PER_UNIT: tpu_q    <= cfg_wdata[TPU_W-1:0];
				REG_RELOAD_PERIOD:  period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Elapsed ticks, counting a reload wrap when the counter went up
	assign elapsed_d = (cur_q > prev_q)
		? (period_q - {1'b0, cur_q} + {1'b0, prev_q})
		: ({1'b0, prev_q} - {1'b0, cur_q});

	// Tick sum: stored remainder plus elapsed ticks
	assign sum_d = {1'b0, rem_q} + {1'b0, elapsed_q};

	// Architectural state: last sample, remainder, unit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			prev_q  <= '0;
			rem_q   <= '0;
			unit_q  <= '0;
		end else begin
			if (accept && first_q) begin
				first_q <= 1'b0;
				prev_q  <= sample.data.counter_value;
			end
			if (state_q == ST_ELAP) prev_q <= cur_q;
			if (state_q == ST_SUM && tpu_q == '0) rem_q <= sum_d[TICKS_W-1:0];
			if (state_q == ST_ADD) begin
				unit_q <= unit_q + TIME_W'(div_quot);
				rem_q  <= TICKS_W'(div_rem);
			end
		end
	end

	// Working registers for the transaction in progress
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q   <= sample.data.counter_value;
			start_q <= sample.data.start_time;
			delay_q <= sample.data.delay_time;
		end
		if (state_q == ST_ELAP) elapsed_q <= elapsed_d;
		if (state_q == ST_DIFF) diff_q    <= unit_q - start_q;
	end

	detk_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (sum_d),
		.divisor   (tpu_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			res_data_q.time_count      <= unit_q;
			res_data_q.interval_passed <= (diff_q >= delay_q);
		end
	end

	assign sample.ready = in_ready;
	assign result.valid = res_valid_q;
	assign result.data  = res_data_q;

	// Divider finishes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside divide state");

	// A new result appears only out of the finish state
	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finish state");

	// Priming happens once after reset
	a_first_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |=> !first_q)
		else $error("first-sample flag set again");

	// Stored remainder is below the divisor after an update
	a_rem_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |=> (rem_q < {1'b0, tpu_q}))
		else $error("tick remainder not reduced");

endmodule
